// ===== rtl/core/sca_pkg.sv =====
`default_nettype none
package sca_pkg;

  localparam int NUM_CHANNELS_DEF  = 8;
  localparam int ORIGIN_BITS_DEF   = 16;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

  localparam int REQ_W = 2;
  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

  localparam int UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t U_START = 3'd0;
  localparam upc_t U_ALLOC = 3'd1;
  localparam upc_t U_STEAL = 3'd2;
  localparam upc_t U_STOP  = 3'd3;
  localparam upc_t U_FREE  = 3'd4;
  localparam upc_t U_NOP   = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MATCH,
    OP_ALLOC,
    OP_STEAL,
    OP_RELEASE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   assign_hit;
    logic   last;
    logic   last_if_hit;
    upc_t   next;
  } ucode_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    logic   load;
    logic   step;
    dp_op_t op;
    logic   assign_hit;
    logic   finish;
  } dp_ctrl_t;

  typedef struct packed {
    logic hit;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/sca_ucode_rom.sv =====
`default_nettype none
module sca_ucode_rom
  import sca_pkg::*;
(
  input  wire upc_t             upc,
  input  wire logic [REQ_W-1:0] req_type,
  output ucode_t                word,
  output upc_t                  entry
);

  always_comb begin
    case (upc)
      U_START: word = '{op: OP_MATCH,   assign_hit: 1'b0, last: 1'b0, last_if_hit: 1'b0,
                        next: U_ALLOC};
      U_ALLOC: word = '{op: OP_ALLOC,   assign_hit: 1'b1, last: 1'b0, last_if_hit: 1'b1,
                        next: U_STEAL};
      U_STEAL: word = '{op: OP_STEAL,   assign_hit: 1'b1, last: 1'b1, last_if_hit: 1'b0,
                        next: U_NOP};
      U_STOP:  word = '{op: OP_MATCH,   assign_hit: 1'b0, last: 1'b1, last_if_hit: 1'b0,
                        next: U_NOP};
      U_FREE:  word = '{op: OP_RELEASE, assign_hit: 1'b0, last: 1'b1, last_if_hit: 1'b0,
                        next: U_NOP};
      default: word = '{op: OP_NONE,    assign_hit: 1'b0, last: 1'b1, last_if_hit: 1'b0,
                        next: U_NOP};
    endcase
  end

  always_comb begin
    case (req_type)
      REQ_START: entry = U_START;
      REQ_STOP:  entry = U_STOP;
      REQ_FREE:  entry = U_FREE;
      default:   entry = U_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/sca_seq.sv =====
`default_nettype none
module sca_seq
  import sca_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [REQ_W-1:0] req_type,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire dp_status_t       status,
  output dp_ctrl_t              ctrl
);

  seq_state_t state_r, state_nxt;
  upc_t       upc_r, upc_nxt;
  logic       out_valid_r, out_valid_nxt;
  ucode_t     word;
  upc_t       entry;
  logic       accept;
  logic       step_en;
  logic       finish;

  sca_ucode_rom u_rom (
    .upc      (upc_r),
    .req_type (req_type),
    .word     (word),
    .entry    (entry)
  );

  assign accept  = in_valid && (state_r == SEQ_IDLE);
  assign step_en = (state_r == SEQ_RUN) && (!out_valid_r || out_ready);
  assign finish  = word.last || (word.last_if_hit && status.hit);

  // next state
  always_comb begin
    state_nxt = state_r;
    upc_nxt   = upc_r;
    case (state_r)
      SEQ_IDLE: begin
        if (accept) begin
          state_nxt = SEQ_RUN;
          upc_nxt   = entry;
        end
      end
      SEQ_RUN: begin
        if (step_en) begin
          if (finish) begin
            state_nxt = SEQ_IDLE;
          end else begin
            upc_nxt = word.next;
          end
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (step_en && finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  // outputs
  always_comb begin
    in_ready        = (state_r == SEQ_IDLE);
    out_valid       = out_valid_r;
    ctrl.load       = accept;
    ctrl.step       = step_en;
    ctrl.op         = word.op;
    ctrl.assign_hit = word.assign_hit;
    ctrl.finish     = finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      upc_r       <= U_NOP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sca_chan_dp.sv =====
`default_nettype none
module sca_chan_dp
  import sca_pkg::*;
#(
  parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF,
  parameter int ORIGIN_BITS   = ORIGIN_BITS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int CH_W          = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
)(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dp_ctrl_t                 ctrl,
  output dp_status_t                    status,
  input  wire logic [CFG_W-1:0]         active_channels,
  input  wire logic [ORIGIN_BITS-1:0]   origin_id,
  input  wire logic                     has_origin,
  input  wire logic [PRIORITY_BITS-1:0] priority_req,
  input  wire logic [CH_W-1:0]          channel_index,
  output logic                          granted,
  output logic [CH_W-1:0]               channel,
  output logic [NUM_CHANNELS-1:0]       stopped_mask
);

  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

  logic [NUM_CHANNELS-1:0]  busy_r;
  logic [NUM_CHANNELS-1:0]  chas_r;
  logic [ORIGIN_BITS-1:0]   corg_r [NUM_CHANNELS];
  logic [PRIORITY_BITS-1:0] cpri_r [NUM_CHANNELS];

  logic                     has_r;
  logic [ORIGIN_BITS-1:0]   org_r;
  logic [PRIORITY_BITS-1:0] pri_r;
  logic [CH_W-1:0]          idx_r;
  logic [NUM_CHANNELS-1:0]  acc_r;

  logic                     granted_r;
  logic [CH_W-1:0]          channel_r;
  logic [NUM_CHANNELS-1:0]  mask_r;

  logic [CNT_W-1:0]         n_eff;
  logic [NUM_CHANNELS-1:0]  inr;
  logic [NUM_CHANNELS-1:0]  match;
  logic [NUM_CHANNELS-1:0]  cand;
  logic [NUM_CHANNELS-1:0]  first_oh;
  logic [CH_W-1:0]          first_idx;
  logic                     hit;
  logic                     grant_now;

  always_comb begin
    if ({{(32-CFG_W){1'b0}}, active_channels} > 32'(NUM_CHANNELS)) begin
      n_eff = CNT_W'(NUM_CHANNELS);
    end else begin
      n_eff = CNT_W'(active_channels);
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      inr[c]   = CNT_W'(c) < n_eff;
      match[c] = busy_r[c] && (chas_r[c] == has_r) && (!has_r || (corg_r[c] == org_r));
      case (ctrl.op)
        OP_MATCH:   cand[c] = inr[c] && match[c];
        OP_ALLOC:   cand[c] = inr[c] && (!busy_r[c] || (has_r && match[c]));
        OP_STEAL:   cand[c] = inr[c] && (cpri_r[c] >= pri_r);
        OP_RELEASE: cand[c] = inr[c] && (idx_r == CH_W'(c));
        default:    cand[c] = 1'b0;
      endcase
    end
  end

  // first candidate from index zero
  always_comb begin
    first_oh  = '0;
    first_idx = '0;
    for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
      if (cand[c]) begin
        first_oh      = '0;
        first_oh[c]   = 1'b1;
        first_idx     = CH_W'(c);
      end
    end
  end

  assign hit        = |cand;
  assign status.hit = hit;
  assign grant_now  = ctrl.assign_hit && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (ctrl.step) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (first_oh[c]) begin
          busy_r[c] <= ctrl.assign_hit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step && ctrl.assign_hit) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (first_oh[c]) begin
          chas_r[c] <= has_r;
          corg_r[c] <= org_r;
          cpri_r[c] <= pri_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      has_r <= has_origin;
      org_r <= has_origin ? origin_id : '0;
      pri_r <= priority_req;
      idx_r <= channel_index;
      acc_r <= '0;
    end else if (ctrl.step) begin
      acc_r <= acc_r | (first_oh & busy_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step && ctrl.finish) begin
      mask_r    <= acc_r | (first_oh & busy_r);
      granted_r <= grant_now;
      channel_r <= grant_now ? first_idx : '0;
    end
  end

  assign granted      = granted_r;
  assign channel      = channel_r;
  assign stopped_mask = mask_r;

endmodule
`default_nettype wire

// ===== rtl/core/sound_channel_allocator.sv =====
`default_nettype none
// channel   direction  ports
// in        input      in_valid / in_ready, req_type origin_id has_origin priority_req ...
// out       output     out_valid / out_ready, granted channel stopped_mask
// cfg       input      cfg_wr_en, cfg_wr_data (active_channels)
//
// one request at a time; a microcode step scans all channels at once
// a start runs 2 or 3 steps, stop and free 1; the result is valid right after the last step
// a transaction holds the block from its acceptance through its last step
// a waiting result holds the next step until out_ready; a new request may be accepted meanwhile
// synchronous reset frees every channel and sets active_channels to 8
module sound_channel_allocator
  import sca_pkg::*;
#(
  parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF,
  parameter int ORIGIN_BITS   = ORIGIN_BITS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int CH_W          = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
)(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_W-1:0]         cfg_wr_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [REQ_W-1:0]         in_req_type,
  input  wire logic [ORIGIN_BITS-1:0]   in_origin_id,
  input  wire logic                     in_has_origin,
  input  wire logic [PRIORITY_BITS-1:0] in_priority_req,
  input  wire logic [CH_W-1:0]          in_channel_index,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_granted,
  output logic [CH_W-1:0]               out_channel,
  output logic [NUM_CHANNELS-1:0]       out_stopped_mask
);

  logic [CFG_W-1:0] active_r;
  dp_ctrl_t         ctrl;
  dp_status_t       status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_wr_en) begin
      active_r <= cfg_wr_data;
    end
  end

  sca_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (in_req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  sca_chan_dp #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .ORIGIN_BITS   (ORIGIN_BITS),
    .PRIORITY_BITS (PRIORITY_BITS),
    .CH_W          (CH_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .status          (status),
    .active_channels (active_r),
    .origin_id       (in_origin_id),
    .has_origin      (in_has_origin),
    .priority_req    (in_priority_req),
    .channel_index   (in_channel_index),
    .granted         (out_granted),
    .channel         (out_channel),
    .stopped_mask    (out_stopped_mask)
  );

endmodule
`default_nettype wire

// ===== tb/sound_channel_allocator_test.sv =====
`timescale 1ns / 100ps

module sound_channel_allocator_test;
  import sca_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int NCH = NUM_CHANNELS_DEF;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic [15:0]      origin;
    logic             has_org;
    logic [7:0]       pri;
    logic [2:0]       idx;
  } voice_req_t;

  typedef struct packed {
    logic       granted;
    logic [2:0] channel;
    logic [7:0] stopped_mask;
  } alloc_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_ready;
  logic [REQ_W-1:0] in_req_type;
  logic [15:0]      in_origin_id;
  logic             in_has_origin;
  logic [7:0]       in_priority_req;
  logic [2:0]       in_channel_index;
  logic             out_valid;
  logic             out_ready;
  logic             out_granted;
  logic [2:0]       out_channel;
  logic [7:0]       out_stopped_mask;

  // voice table as the block should hold it
  logic             ch_busy [NCH];
  logic             ch_has_org [NCH];
  logic [15:0]      ch_org [NCH];
  logic [7:0]       ch_pri [NCH];
  logic [CFG_W-1:0] active_cnt;

  alloc_t expected_allocs[$];
  alloc_t head;
  int     n_errors = 0;
  int     n_requests = 0;
  int     n_results = 0;
  int     n_granted = 0;
  int     n_rejected_starts = 0;
  logic   tx_quiet = 1'b0;
  logic   rx_quiet = 1'b0;

  sound_channel_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_origin_id     (in_origin_id),
    .in_has_origin    (in_has_origin),
    .in_priority_req  (in_priority_req),
    .in_channel_index (in_channel_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted      (out_granted),
    .out_channel      (out_channel),
    .out_stopped_mask (out_stopped_mask)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still pending", expected_allocs.size());
    $display("Test completed with failures");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  function automatic logic origin_hit(input int c, input logic has, input logic [15:0] org);
    if (ch_has_org[c] != has)
      return 1'b0;
    return !has || ch_org[c] == org;
  endfunction

  function automatic logic [7:0] release_chan(input int c);
    if (!ch_busy[c])
      return 8'h00;
    ch_busy[c] = 1'b0;
    ch_has_org[c] = 1'b0;
    ch_org[c] = '0;
    ch_pri[c] = '0;
    return 8'h01 << c;
  endfunction

  function automatic logic [7:0] stop_first_owner(input int n, input logic has,
                                                  input logic [15:0] org);
    int c;
    for (c = 0; c < n; c++) begin
      if (ch_busy[c] && origin_hit(c, has, org))
        return release_chan(c);
    end
    return 8'h00;
  endfunction

  function automatic alloc_t predict_alloc(input voice_req_t r);
    alloc_t      res;
    int          n;
    int          c;
    int          hit;
    logic [15:0] org;
    res = '0;
    n = (active_cnt > NCH) ? NCH : int'(active_cnt);
    org = r.has_org ? r.origin : 16'h0000;
    case (r.kind)
      REQ_START: begin
        res.stopped_mask |= stop_first_owner(n, r.has_org, org);
        hit = n;
        for (c = 0; c < n; c++) begin
          if (!ch_busy[c]) begin
            hit = c;
            break;
          end
          if (r.has_org && origin_hit(c, r.has_org, org)) begin
            res.stopped_mask |= release_chan(c);
            hit = c;
            break;
          end
        end
        if (hit == n) begin
          for (c = 0; c < n; c++) begin
            if (ch_pri[c] >= r.pri) begin
              hit = c;
              break;
            end
          end
          if (hit < n)
            res.stopped_mask |= release_chan(hit);
        end
        if (hit < n) begin
          ch_busy[hit] = 1'b1;
          ch_has_org[hit] = r.has_org;
          ch_org[hit] = org;
          ch_pri[hit] = r.pri;
          res.granted = 1'b1;
          res.channel = hit[2:0];
        end
      end
      REQ_STOP: begin
        res.stopped_mask |= stop_first_owner(n, r.has_org, org);
      end
      REQ_FREE: begin
        if (int'(r.idx) < n)
          res.stopped_mask |= release_chan(r.idx);
      end
      default: ;
    endcase
    return res;
  endfunction

  // leaves in_valid high after the transaction; whoever waits next lowers it
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [15:0] org,
                          input logic has, input logic [7:0] pri, input logic [2:0] idx);
    int         gap;
    voice_req_t r;
    alloc_t     want;
    if ($urandom_range(0, 39) == 0)
      tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= kind;
    in_origin_id     <= org;
    in_has_origin    <= has;
    in_priority_req  <= pri;
    in_channel_index <= idx;
    do @(posedge clk); while (!in_ready);
    r = '{kind: kind, origin: org, has_org: has, pri: pri, idx: idx};
    want = predict_alloc(r);
    if (kind == REQ_START) begin
      if (want.granted)
        n_granted++;
      else
        n_rejected_starts++;
    end
    expected_allocs.push_back(want);
    n_requests++;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_allocs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_active(input logic [CFG_W-1:0] value);
    wait_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    active_cnt = value;
  endtask

  task automatic send_random_req();
    logic [REQ_W-1:0] kind;
    logic [15:0]      org;
    logic [7:0]       pri;
    int               pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      kind = REQ_START;
    else if (pick < 65)
      kind = REQ_STOP;
    else if (pick < 95)
      kind = REQ_FREE;
    else
      kind = REQ_UNUSED;
    // a small pool of owners so that replacement and stop hit often
    case ($urandom_range(0, 5))
      0: org = 16'h0000;
      1: org = 16'hFFFF;
      2: org = 16'h5A5A;
      3: org = 16'h0001;
      default: org = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 5))
      0: pri = 8'h00;
      1: pri = 8'hFF;
      2: pri = 8'h80;
      default: pri = 8'($urandom_range(0, 255));
    endcase
    send_req(kind, org, $urandom_range(0, 9) < 7, pri, 3'($urandom_range(0, 7)));
  endtask

  task automatic test_fill_and_steal();
    int k;
    send_req(REQ_START, 16'h0000, 1'b0, 8'h80, 3'd0);
    send_req(REQ_START, 16'hFFFF, 1'b1, 8'hFF, 3'd7);
    // same owner again replaces its own voice
    send_req(REQ_START, 16'hFFFF, 1'b1, 8'h10, 3'd0);
    // no owner matches no owner
    send_req(REQ_START, 16'hABCD, 1'b0, 8'h00, 3'd0);
    for (k = 1; k <= 6; k++)
      send_req(REQ_START, 16'(k), 1'b1, 8'h40, 3'd0);
    // table full: nothing at or above 0xff, so rejected
    send_req(REQ_START, 16'h1234, 1'b1, 8'hFF, 3'd0);
    // lowest request steals the first channel
    send_req(REQ_START, 16'h5555, 1'b1, 8'h00, 3'd0);
  endtask

  task automatic test_stop_and_free();
    send_req(REQ_STOP, 16'h5555, 1'b1, 8'h00, 3'd0);
    send_req(REQ_STOP, 16'hAAAA, 1'b1, 8'h00, 3'd0);
    send_req(REQ_STOP, 16'h0000, 1'b0, 8'hFF, 3'd0);
    send_req(REQ_FREE, 16'h0000, 1'b0, 8'h00, 3'd7);
    send_req(REQ_FREE, 16'h0000, 1'b0, 8'h00, 3'd7);
    send_req(REQ_UNUSED, 16'hFFFF, 1'b1, 8'hFF, 3'd7);
  endtask

  task automatic test_active_count_limits();
    set_active(4'd0);
    send_req(REQ_START, 16'h0000, 1'b0, 8'h00, 3'd0);
    send_req(REQ_STOP, 16'h0002, 1'b1, 8'h00, 3'd0);
    send_req(REQ_FREE, 16'h0000, 1'b0, 8'h00, 3'd0);
    set_active(4'd15);
    send_req(REQ_START, 16'h0003, 1'b1, 8'h20, 3'd0);
    set_active(4'd1);
    send_req(REQ_START, 16'hFFFF, 1'b1, 8'h00, 3'd0);
    send_req(REQ_FREE, 16'h0000, 1'b0, 8'h00, 3'd3);
    send_req(REQ_STOP, 16'h0004, 1'b1, 8'h00, 3'd0);
    send_req(REQ_FREE, 16'h0000, 1'b0, 8'h00, 3'd0);
    set_active(4'd8);
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] counts [9];
    int               sizes [9];
    int               p;
    int               k;
    counts = '{4'd8, 4'd3, 4'd1, 4'd15, 4'd0, 4'd5, 4'd8, 4'd2, 4'd8};
    sizes  = '{120, 80, 40, 100, 20, 80, 120, 40, 100};
    for (p = 0; p < 9; p++) begin
      set_active(counts[p]);
      for (k = 0; k < sizes[p]; k++)
        send_random_req();
    end
  endtask

  // result side: random back-pressure per transaction
  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0)
        rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_allocs.size() == 0) begin
        flag_error($sformatf("result with nothing pending: granted %0b channel %0d mask %02h",
                             out_granted, out_channel, out_stopped_mask));
      end else begin
        head = expected_allocs.pop_front();
        if (out_granted !== head.granted)
          flag_error($sformatf("granted got %0b, expected %0b", out_granted, head.granted));
        if (out_channel !== head.channel)
          flag_error($sformatf("channel got %0d, expected %0d", out_channel, head.channel));
        if (out_stopped_mask !== head.stopped_mask)
          flag_error($sformatf("stopped_mask got %02h, expected %02h",
                               out_stopped_mask, head.stopped_mask));
      end
    end
  end

  initial begin
    int c;
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_valid         <= 1'b0;
    in_req_type      <= REQ_START;
    in_origin_id     <= '0;
    in_has_origin    <= 1'b0;
    in_priority_req  <= '0;
    in_channel_index <= '0;
    for (c = 0; c < NCH; c++) begin
      ch_busy[c] = 1'b0;
      ch_has_org[c] = 1'b0;
      ch_org[c] = '0;
      ch_pri[c] = '0;
    end
    active_cnt = ACTIVE_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_and_steal();
    test_stop_and_free();
    test_active_count_limits();
    test_random_traffic();

    wait_quiet();
    repeat (8) @(posedge clk);
    $display("%0d requests sent, %0d results checked, %0d starts granted, %0d rejected",
             n_requests, n_results, n_granted, n_rejected_starts);
    $display("active channel counts from 0 to 15 exercised, %0d mismatches", n_errors);
    if (n_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
